/* hdl/rca_pkg.sv */
// rca_pkg: shared types and constants for the retry concurrency admission block
// event codes, register indexes, stream widths and the controller/datapath interface
// no dependencies
`timescale 1ns / 1ps

package rca_pkg;

  typedef enum logic [2:0] {
    ACT_TRY_STARTED      = 3'd0,
    ACT_TRY_SUCCEEDED    = 3'd1,
    ACT_SUCCESS_FINISHED = 3'd2,
    ACT_TRY_ABORTED      = 3'd3,
    ACT_RETRY_REQUEST    = 3'd4,
    ACT_STREAM_OPEN      = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    CFG_BUDGET    = 2'd0,
    CFG_MIN_LIMIT = 2'd1,
    CFG_STATS_EN  = 2'd2
  } cfg_idx_e;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 3;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned SID_W      = 6;
  localparam int unsigned ATT_W      = 5;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned STRY_W     = 8;
  localparam int unsigned BUD_W      = 14;
  localparam int unsigned PROD_W     = CNT_W + BUD_W;

  localparam logic [BUD_W-1:0]  BUDGET_MAX    = 14'd10000;
  localparam logic [BUD_W-1:0]  BUDGET_RESET  = 14'd2000;
  localparam logic [CNT_W-1:0]  MIN_LIM_RESET = 16'd3;
  // floor(x / 10000) = (x * ceil(2^44 / 10000)) >> 44, exact for x below 2^30
  localparam logic [30:0]       RECIP_M       = 31'd1759218605;
  localparam int unsigned       RECIP_SHIFT   = 44;
  localparam int unsigned       RECIP_PROD_W  = PROD_W + 31;

  typedef struct packed {
    logic accept_en;
    logic mul1;
    logic mul2;
    logic update;
    logic result;
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic out_free;
  } status_t;

endpackage

/* hdl/rca_ram.sv */
// rca_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rca_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/rca_ctrl.sv */
// rca_ctrl: sequencer for one request at a time through read, limit, update and result
// depends on rca_pkg
`timescale 1ns / 1ps

module rca_ctrl
  import rca_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIM_A1,
    S_LIM_A2,
    S_UPDATE,
    S_LIM_B1,
    S_LIM_B2,
    S_RESULT
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= '{accept_en: 1'b1, default: 1'b0};
    end else begin
      case (state_q)
        S_IDLE: begin
          if (status_i.in_fire) begin
            state_q <= S_LIM_A1;
            cmd_q   <= '{mul1: 1'b1, default: 1'b0};
          end
        end
        S_LIM_A1: begin
          state_q <= S_LIM_A2;
          cmd_q   <= '{mul2: 1'b1, default: 1'b0};
        end
        S_LIM_A2: begin
          state_q <= S_UPDATE;
          cmd_q   <= '{update: 1'b1, default: 1'b0};
        end
        S_UPDATE: begin
          state_q <= S_LIM_B1;
          cmd_q   <= '{mul1: 1'b1, default: 1'b0};
        end
        S_LIM_B1: begin
          state_q <= S_LIM_B2;
          cmd_q   <= '{mul2: 1'b1, default: 1'b0};
        end
        S_LIM_B2: begin
          state_q <= S_RESULT;
          cmd_q   <= '{result: 1'b1, default: 1'b0};
        end
        S_RESULT: begin
          if (status_i.out_free) begin
            state_q <= S_IDLE;
            cmd_q   <= '{accept_en: 1'b1, default: 1'b0};
          end
        end
        default: begin
          state_q <= S_IDLE;
          cmd_q   <= '{accept_en: 1'b1, default: 1'b0};
        end
      endcase
    end
  end

  assign cmd_o = cmd_q;

endmodule

/* hdl/rca_dp.sv */
// rca_dp: counters, stream table, limit multiplier, event update and output register
// depends on rca_pkg and rca_ram
`timescale 1ns / 1ps

module rca_dp
  import rca_pkg::*;
#(
  parameter int unsigned STREAMS      = 64,
  parameter int unsigned MAX_ATTEMPTS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  input  logic [IN_USER_W-1:0]  in_user_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned DEPTH = (STREAMS < 64) ? STREAMS : 64;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MW    = MAX_ATTEMPTS;
  localparam int unsigned EW    = MW + STRY_W;

  // configuration
  logic [BUD_W-1:0] budget_q;
  logic [CNT_W-1:0] min_lim_q;
  logic             stats_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q   <= BUDGET_RESET;
      min_lim_q  <= MIN_LIM_RESET;
      stats_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BUDGET:    budget_q   <= cfg_wdata_i[BUD_W-1:0];
        CFG_MIN_LIMIT: min_lim_q  <= cfg_wdata_i;
        CFG_STATS_EN:  stats_en_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request capture
  logic             in_fire;
  logic [2:0]       act_q;
  logic [SID_W-1:0] sid_q;
  logic [ATT_W-1:0] att_q;
  logic [ATT_W-1:0] prev_q;
  logic [ATT_W-1:0] ratt_q;
  logic             abort_q;

  assign in_fire = in_valid_i && cmd_i.accept_en;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      act_q   <= in_user_i;
      sid_q   <= in_data_i[5:0];
      att_q   <= in_data_i[10:6];
      prev_q  <= in_data_i[15:11];
      ratt_q  <= in_data_i[20:16];
      abort_q <= in_data_i[21];
    end
  end

  // stream table
  logic          sid_ok;
  logic [AW-1:0] addr;
  logic [EW-1:0] rdata;
  logic [EW-1:0] wdata;
  logic          tbl_we;
  logic [DEPTH-1:0] vld_q;
  logic          entry_ok;

  assign sid_ok   = (32'(sid_q) < STREAMS);
  assign addr     = sid_q[AW-1:0];
  assign tbl_we   = cmd_i.update && sid_ok;
  assign entry_ok = sid_ok && vld_q[addr];

  rca_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (addr),
    .wdata_i (wdata),
    .re_i    (in_fire),
    .raddr_i (in_data_i[AW-1:0]),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (tbl_we) begin
      vld_q[addr] <= 1'b1;
    end
  end

  // limit unit
  logic [CNT_W-1:0]  gt_q;
  logic [CNT_W-1:0]  gr_q;
  logic [BUD_W-1:0]  bud;
  logic [PROD_W-1:0] prod_q;
  logic [CNT_W-1:0]  quot_q;
  logic [CNT_W-1:0]  lim;

  assign bud = (budget_q > BUDGET_MAX) ? BUDGET_MAX : budget_q;
  assign lim = (quot_q < min_lim_q) ? min_lim_q : quot_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      prod_q <= PROD_W'({14'd0, gt_q} * {16'd0, bud});
    end
    if (cmd_i.mul2) begin
      quot_q <= CNT_W'((RECIP_PROD_W'(prod_q) * RECIP_PROD_W'(RECIP_M)) >> RECIP_SHIFT);
    end
  end

  // event update
  logic [MW-1:0]     mask_rd, mask_n, abit, pbit, rbit;
  logic [STRY_W-1:0] st_rd, st_n;
  logic [CNT_W-1:0]  gt_n, gr_n;
  logic              hit_a, hit_p, diff, ok, sat, refresh, admit;

  assign mask_rd = entry_ok ? rdata[EW-1:STRY_W] : '0;
  assign st_rd   = entry_ok ? rdata[STRY_W-1:0] : '0;
  assign wdata   = {mask_n, st_n};

  always_comb begin
    for (int i = 0; i < MW; i++) begin
      abit[i] = (32'(att_q) == i);
      pbit[i] = (32'(prev_q) == i);
      rbit[i] = (32'(ratt_q) == i);
    end
  end

  assign hit_a = |(mask_rd & abit);
  assign hit_p = |(mask_rd & pbit);
  assign diff  = !(abort_q && hit_p);
  assign ok    = (({1'b0, gr_q} + 17'(diff)) <= {1'b0, lim});

  always_comb begin
    mask_n  = mask_rd;
    st_n    = st_rd;
    gt_n    = gt_q;
    gr_n    = gr_q;
    sat     = 1'b0;
    refresh = 1'b0;
    admit   = 1'b0;
    case (act_q)
      ACT_TRY_STARTED: begin
        if (!hit_a) begin
          if (gt_q == '1) sat = 1'b1; else gt_n = gt_q + 1'b1;
          if (st_rd == '1) sat = 1'b1; else st_n = st_rd + 1'b1;
          refresh = 1'b1;
        end
      end
      ACT_TRY_SUCCEEDED: begin
        if (hit_a) begin
          mask_n = mask_rd & ~abit;
          if (gr_q == '0) sat = 1'b1; else gr_n = gr_q - 1'b1;
          refresh = 1'b1;
        end
      end
      ACT_SUCCESS_FINISHED: begin
        if (gt_q == '0) sat = 1'b1; else gt_n = gt_q - 1'b1;
        if (st_rd == '0) sat = 1'b1; else st_n = st_rd - 1'b1;
        refresh = 1'b1;
      end
      ACT_TRY_ABORTED: begin
        if (hit_a) begin
          mask_n = mask_rd & ~abit;
          if (gr_q == '0) sat = 1'b1; else gr_n = gr_q - 1'b1;
        end
        if (gt_q == '0) sat = 1'b1; else gt_n = gt_q - 1'b1;
        if (st_rd == '0) sat = 1'b1; else st_n = st_rd - 1'b1;
        refresh = 1'b1;
      end
      ACT_RETRY_REQUEST: begin
        if (ok) begin
          admit = 1'b1;
          if (diff) begin
            if (gr_q == '1) sat = 1'b1; else gr_n = gr_q + 1'b1;
          end
          if (abort_q) begin
            mask_n = mask_rd & ~pbit;
          end else begin
            if (gt_q == '1) sat = 1'b1; else gt_n = gt_q + 1'b1;
            if (st_rd == '1) sat = 1'b1; else st_n = st_rd + 1'b1;
          end
          mask_n  = mask_n | rbit;
          refresh = 1'b1;
        end
      end
      ACT_STREAM_OPEN: begin
        mask_n = '0;
        st_n   = '0;
      end
      default: ;
    endcase
  end

  logic              admit_q, upd_q, sat_q;
  logic [STRY_W-1:0] st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= '0;
      gr_q <= '0;
    end else if (cmd_i.update) begin
      gt_q <= gt_n;
      gr_q <= gr_n;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      admit_q <= admit;
      upd_q   <= refresh && stats_en_q;
      sat_q   <= sat;
      st_q    <= st_n;
    end
  end

  // result register
  logic [CNT_W-1:0]      rem;
  logic                  out_free, load;
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  assign rem      = (gr_q > lim) ? '0 : lim - gr_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign load     = cmd_i.result && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_data_q <= {4'd0, sat_q, st_q, gr_q, gt_q, (rem == '0), rem, upd_q, admit_q};
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.in_fire  = in_fire;
  assign status_o.out_free = out_free;

endmodule

/* hdl/retry_concurrency_admission.sv */
// retry_concurrency_admission: top level of the retry admission block
// depends on rca_pkg, rca_ctrl and rca_dp (which holds rca_ram)
//
// channel        dir  handshake                      payload
// s_axis         in   s_axis_tvalid / s_axis_tready  tdata 24b, tuser 3b
// m_axis         out  m_axis_tvalid / m_axis_tready  tdata 64b
// cfg            in   cfg_we_i (no wait)             cfg_idx_i 2b, cfg_wdata_i 16b
//
// requests are taken one at a time, each going through the table read, then two passes through the
// two-stage limit multiplier (before and after the counter update) and a result cycle
// the result sits in an output register; a stalled sink holds only the result cycle
// reset clears counters and the per-stream valid bits at once, no clearing pass
`timescale 1ns / 1ps

module retry_concurrency_admission
  import rca_pkg::*;
#(
  parameter int unsigned STREAMS      = 64,
  parameter int unsigned MAX_ATTEMPTS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // stream_id, attempt, prev_attempt, retry_attempt, abort_previous, zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action
  input  logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // admitted, stats_updated, remaining_retries, retry_open, total_tries,
  // total_retries, stream_tries, count_error, zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  rca_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  rca_dp #(
    .STREAMS      (STREAMS),
    .MAX_ATTEMPTS (MAX_ATTEMPTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  assign s_axis_tready = cmd.accept_en;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(cmd))
    else $error("controller commands not one-hot");

  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one in flight");

  a_open_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18] == (m_axis_tdata[17:2] == 16'd0)))
    else $error("retry_open disagrees with remaining_retries");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.result && status.out_free) |=> m_axis_tvalid)
    else $error("result not presented after load");

endmodule
